// ===== design/imu_fp_pkg.sv =====
// shared types, constants and helpers for the imu frame parser
`default_nettype none

package imu_fp_pkg;

    // frame constants
    localparam logic [7:0] SYNC_BYTE    = 8'h55;
    localparam logic [7:0] KIND_ANGLE   = 8'h01;
    localparam logic [7:0] KIND_QUAT    = 8'h02;
    localparam logic [7:0] KIND_MOTION  = 8'h03;
    localparam int         PAYLOAD_KEEP = 12;
    localparam int         KEEP_W       = $clog2(PAYLOAD_KEEP);
    localparam int         POS_W        = 9;
    localparam int         WORD_W       = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_ANGLE_POS  = 2'd0;
    localparam logic [1:0] CFG_QUAT_POS   = 2'd1;
    localparam logic [1:0] CFG_MOTION_POS = 2'd2;

    // reset values of the checksum positions
    localparam logic [POS_W-1:0] ANGLE_POS_RST  = 9'd10;
    localparam logic [POS_W-1:0] QUAT_POS_RST   = 9'd12;
    localparam logic [POS_W-1:0] MOTION_POS_RST = 9'd16;
    localparam logic [POS_W-1:0] POS_NONE       = 9'h1FF;

    typedef struct packed {
        logic [POS_W-1:0] angle_pos;
        logic [POS_W-1:0] quat_pos;
        logic [POS_W-1:0] motion_pos;
    } cfg_t;

    typedef struct packed {
        logic [1:0]               category;
        logic                     checksum_ok;
        logic signed [WORD_W-1:0] word0;
        logic signed [WORD_W-1:0] word1;
        logic signed [WORD_W-1:0] word2;
        logic signed [WORD_W-1:0] word3;
        logic signed [WORD_W-1:0] word4;
        logic signed [WORD_W-1:0] word5;
    } result_t;

    // checksum position for a frame type, none for unknown types
    function automatic logic [POS_W-1:0] check_pos(input cfg_t cfg, input logic [7:0] kind);
        logic [POS_W-1:0] pos;
        case (kind)
            KIND_ANGLE:  pos = cfg.angle_pos;
            KIND_QUAT:   pos = cfg.quat_pos;
            KIND_MOTION: pos = cfg.motion_pos;
            default:     pos = POS_NONE;
        endcase
        return pos;
    endfunction

endpackage

`default_nettype wire

// ===== design/imu_fp_parser.sv =====
// byte-level frame parser: sync hunt, header, checksum and payload store
`default_nettype none

module imu_fp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_take,
    input  wire logic [7:0]        rx_byte,
    input  wire imu_fp_pkg::cfg_t  cfg,
    output logic                   res_fire,
    output imu_fp_pkg::result_t    res
);

    localparam logic [2:0] PH_HUNT1 = 3'd0;
    localparam logic [2:0] PH_HUNT2 = 3'd1;
    localparam logic [2:0] PH_TYPE  = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_BODY  = 3'd4;

    localparam int PW = imu_fp_pkg::POS_W;

    logic [2:0]    phase_reg, phase_next;
    logic [PW-1:0] index_reg, index_next;
    logic [7:0]    kind_reg, kind_next;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    cb_reg, cb_next;
    logic          seen_reg, seen_next;
    logic [7:0]    store_reg [imu_fp_pkg::PAYLOAD_KEEP];
    logic [7:0]    store_next [imu_fp_pkg::PAYLOAD_KEEP];

    logic [PW-1:0] pos;
    logic [PW-1:0] pay_idx;
    logic [PW-1:0] frame_end;
    logic [7:0]    s0, s1;
    logic          known;

    // checksum position follows the type byte while it arrives
    always_comb
    begin
        if (phase_reg == PH_TYPE)
            pos = imu_fp_pkg::check_pos(cfg, rx_byte);
        else
            pos = imu_fp_pkg::check_pos(cfg, kind_reg);
    end

    assign pay_idx   = index_reg - PW'(4);
    assign frame_end = PW'(len_reg) + PW'(4);
    assign s0        = (pos != PW'(0)) ? imu_fp_pkg::SYNC_BYTE : 8'd0;
    assign s1        = s0 + ((pos > PW'(1)) ? imu_fp_pkg::SYNC_BYTE : 8'd0);
    assign known     = (kind_reg == imu_fp_pkg::KIND_ANGLE) ||
                       (kind_reg == imu_fp_pkg::KIND_QUAT)  ||
                       (kind_reg == imu_fp_pkg::KIND_MOTION);

    // next state for one received byte
    always_comb
    begin
        phase_next = phase_reg;
        index_next = index_reg;
        kind_next  = kind_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        cb_next    = cb_reg;
        seen_next  = seen_reg;
        store_next = store_reg;
        res_fire   = 1'b0;
        if (byte_take)
        begin
            case (phase_reg)
                PH_HUNT1:
                begin
                    if (rx_byte == imu_fp_pkg::SYNC_BYTE)
                        phase_next = PH_HUNT2;
                end
                PH_HUNT2:
                begin
                    phase_next = (rx_byte == imu_fp_pkg::SYNC_BYTE) ? PH_TYPE : PH_HUNT1;
                    index_next = PW'(2);
                end
                PH_TYPE:
                begin
                    // two sync bytes and the type byte go through the sum at once
                    kind_next = rx_byte;
                    for (int i = 0; i < imu_fp_pkg::PAYLOAD_KEEP; i++)
                        store_next[i] = 8'd0;
                    sum_next  = s1 + ((pos > PW'(2)) ? rx_byte : 8'd0);
                    seen_next = (pos <= PW'(2));
                    if (pos == PW'(2))
                        cb_next = rx_byte;
                    else if (pos < PW'(2))
                        cb_next = imu_fp_pkg::SYNC_BYTE;
                    else
                        cb_next = 8'd0;
                    index_next = PW'(3);
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next = rx_byte;
                    if (PW'(3) < pos)
                        sum_next = sum_reg + rx_byte;
                    else if (PW'(3) == pos)
                    begin
                        cb_next   = rx_byte;
                        seen_next = 1'b1;
                    end
                    index_next = PW'(4);
                    phase_next = PH_BODY;
                end
                PH_BODY:
                begin
                    // keep the first payload bytes
                    if ((pay_idx < PW'(len_reg)) &&
                        (pay_idx < PW'(imu_fp_pkg::PAYLOAD_KEEP)))
                        store_next[pay_idx[imu_fp_pkg::KEEP_W-1:0]] = rx_byte;
                    if (index_reg < pos)
                        sum_next = sum_reg + rx_byte;
                    else if (index_reg == pos)
                    begin
                        cb_next   = rx_byte;
                        seen_next = 1'b1;
                    end
                    if (index_reg < frame_end)
                        index_next = index_reg + PW'(1);
                    else
                    begin
                        phase_next = PH_HUNT1;
                        index_next = PW'(0);
                        res_fire   = known;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT1;
                end
            endcase
        end
    end

    // result assembled from the updated frame state
    always_comb
    begin
        res.category    = kind_reg[1:0];
        res.checksum_ok = seen_next && (cb_next == sum_next);
        res.word0       = {store_next[1], store_next[0]};
        res.word1       = {store_next[3], store_next[2]};
        res.word2       = {store_next[5], store_next[4]};
        res.word3       = (kind_reg == imu_fp_pkg::KIND_ANGLE) ? 16'sd0
                          : {store_next[7], store_next[6]};
        res.word4       = (kind_reg == imu_fp_pkg::KIND_MOTION)
                          ? {store_next[9], store_next[8]} : 16'sd0;
        res.word5       = (kind_reg == imu_fp_pkg::KIND_MOTION)
                          ? {store_next[11], store_next[10]} : 16'sd0;
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT1;
            index_reg <= '0;
            kind_reg  <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            cb_reg    <= '0;
            seen_reg  <= 1'b0;
            for (int i = 0; i < imu_fp_pkg::PAYLOAD_KEEP; i++)
                store_reg[i] <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            index_reg <= index_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            cb_reg    <= cb_next;
            seen_reg  <= seen_next;
            store_reg <= store_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/imu_frame_parser_top.sv =====
// top level of the imu frame parser: config registers, parser and result register
//
//   channel  direction  handshake            payload
//   in       request in in_valid / in_stall  rx_byte
//   out      request out out_valid/out_stall category, checksum_ok, word0..word5
//   cfg      write in   cfg_we               cfg_index, cfg_data
//
// one byte is taken per cycle while in_stall is low; the parser state updates in the same cycle
// a frame result appears in the result register the cycle after its last byte
// in_stall is high only while a result waits and out_stall is high
// reset returns to sync hunt and sets the checksum positions to 10, 12 and 16
`default_nettype none

module imu_frame_parser_top (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [7:0]              rx_byte,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   category,
    output logic                         checksum_ok,
    output logic signed [15:0]           word0,
    output logic signed [15:0]           word1,
    output logic signed [15:0]           word2,
    output logic signed [15:0]           word3,
    output logic signed [15:0]           word4,
    output logic signed [15:0]           word5,
    input  wire logic                    cfg_we,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [8:0]              cfg_data
);

    imu_fp_pkg::cfg_t    cfg_reg;
    imu_fp_pkg::result_t res;
    imu_fp_pkg::result_t res_reg;
    logic                res_fire;
    logic                byte_take;
    logic                out_valid_reg;

    // accept a byte unless a result is waiting and blocked
    assign in_stall  = out_valid_reg && out_stall;
    assign byte_take = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_pos  <= imu_fp_pkg::ANGLE_POS_RST;
            cfg_reg.quat_pos   <= imu_fp_pkg::QUAT_POS_RST;
            cfg_reg.motion_pos <= imu_fp_pkg::MOTION_POS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imu_fp_pkg::CFG_ANGLE_POS:  cfg_reg.angle_pos  <= cfg_data;
                imu_fp_pkg::CFG_QUAT_POS:   cfg_reg.quat_pos   <= cfg_data;
                imu_fp_pkg::CFG_MOTION_POS: cfg_reg.motion_pos <= cfg_data;
                default:                    ;
            endcase
        end
    end

    imu_fp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_take (byte_take),
        .rx_byte   (rx_byte),
        .cfg       (cfg_reg),
        .res_fire  (res_fire),
        .res       (res)
    );

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_fire)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (res_fire)
            res_reg <= res;
    end

    assign out_valid   = out_valid_reg;
    assign category    = res_reg.category;
    assign checksum_ok = res_reg.checksum_ok;
    assign word0       = res_reg.word0;
    assign word1       = res_reg.word1;
    assign word2       = res_reg.word2;
    assign word3       = res_reg.word3;
    assign word4       = res_reg.word4;
    assign word5       = res_reg.word5;

endmodule

`default_nettype wire

// ===== dv/tb_imu_frame_parser_top.sv =====
// testbench for the imu frame parser: byte stimulus, frame prediction and result checks
`timescale 1ns / 100ps

module tb_imu_frame_parser_top;

    localparam int HALF_PERIOD    = 2;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int ITEM_BUDGET    = 950;
    localparam int CFG_INTERVAL   = 60;
    localparam int HOLD_CYCLES    = 300;

    // spare register index, writes to it have no effect
    localparam logic [1:0] CFG_SPARE = 2'd3;

    // payload fill patterns for directed frames
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam int FILL_EXTREME = 3;

    // predicted parser phases
    localparam logic [2:0] HUNT_FIRST  = 3'd0;
    localparam logic [2:0] HUNT_SECOND = 3'd1;
    localparam logic [2:0] GET_KIND    = 3'd2;
    localparam logic [2:0] GET_LENGTH  = 3'd3;
    localparam logic [2:0] GET_BODY    = 3'd4;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] rx_byte;
    logic out_valid;
    logic out_stall;
    logic [1:0] category;
    logic checksum_ok;
    logic signed [15:0] word0;
    logic signed [15:0] word1;
    logic signed [15:0] word2;
    logic signed [15:0] word3;
    logic signed [15:0] word4;
    logic signed [15:0] word5;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [8:0] cfg_data;

    // predicted parser state and checksum positions
    logic [2:0] ph;
    logic [8:0] idx;
    logic [7:0] kind_r;
    logic [7:0] len_r;
    logic [7:0] sum_r;
    logic [7:0] chk_r;
    logic seen_r;
    logic [7:0] store [imu_fp_pkg::PAYLOAD_KEEP];
    logic [8:0] pos_angle;
    logic [8:0] pos_quat;
    logic [8:0] pos_motion;

    imu_fp_pkg::result_t frames_due[$];
    imu_fp_pkg::result_t want;
    int errors;
    int rx_sent;
    bit steady_in;
    bit steady_out;
    bit hold_request;

    imu_frame_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .category    (category),
        .checksum_ok (checksum_ok),
        .word0       (word0),
        .word1       (word1),
        .word2       (word2),
        .word3       (word3),
        .word4       (word4),
        .word5       (word5),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // checksum position of a frame type under the current settings
    function automatic logic [8:0] kind_pos(input logic [7:0] k);
        case (k)
            imu_fp_pkg::KIND_ANGLE:  return pos_angle;
            imu_fp_pkg::KIND_QUAT:   return pos_quat;
            imu_fp_pkg::KIND_MOTION: return pos_motion;
            default:                 return imu_fp_pkg::POS_NONE;
        endcase
    endfunction

    // sum bytes below the check position, capture the byte at it
    task automatic fold_byte(input logic [8:0] i, input logic [7:0] b);
        logic [8:0] p;
        p = kind_pos(kind_r);
        if (i < p)
            sum_r = sum_r + b;
        else if (i == p)
        begin
            chk_r  = b;
            seen_r = 1'b1;
        end
    endtask

    // advance the predicted parser by one byte, queue a frame result when one ends
    task automatic parse_rx_byte(input logic [7:0] b);
        int slot;
        int nwords;
        logic signed [15:0] w [6];
        imu_fp_pkg::result_t r;
        case (ph)
            HUNT_FIRST:
                if (b == imu_fp_pkg::SYNC_BYTE)
                    ph = HUNT_SECOND;
            HUNT_SECOND:
            begin
                ph  = (b == imu_fp_pkg::SYNC_BYTE) ? GET_KIND : HUNT_FIRST;
                idx = 9'd2;
            end
            GET_KIND:
            begin
                kind_r = b;
                sum_r  = 8'd0;
                chk_r  = 8'd0;
                seen_r = 1'b0;
                for (int i = 0; i < imu_fp_pkg::PAYLOAD_KEEP; i++)
                    store[i] = 8'd0;
                fold_byte(9'd0, imu_fp_pkg::SYNC_BYTE);
                fold_byte(9'd1, imu_fp_pkg::SYNC_BYTE);
                fold_byte(9'd2, b);
                idx = 9'd3;
                ph  = GET_LENGTH;
            end
            GET_LENGTH:
            begin
                len_r = b;
                fold_byte(9'd3, b);
                idx = 9'd4;
                ph  = GET_BODY;
            end
            default:
            begin
                slot = int'(idx) - 4;
                if (slot < int'(len_r) && slot < imu_fp_pkg::PAYLOAD_KEEP)
                    store[slot] = b;
                fold_byte(idx, b);
                if (int'(idx) < int'(len_r) + 4)
                    idx = idx + 9'd1;
                else
                begin
                    ph  = HUNT_FIRST;
                    idx = 9'd0;
                    case (kind_r)
                        imu_fp_pkg::KIND_ANGLE:  nwords = 3;
                        imu_fp_pkg::KIND_QUAT:   nwords = 4;
                        imu_fp_pkg::KIND_MOTION: nwords = 6;
                        default:                 nwords = 0;
                    endcase
                    if (nwords > 0)
                    begin
                        for (int k = 0; k < 6; k++)
                            w[k] = (k < nwords) ? {store[2*k+1], store[2*k]} : 16'sd0;
                        r.category    = kind_r[1:0];
                        r.checksum_ok = seen_r && (chk_r == sum_r);
                        r.word0 = w[0];
                        r.word1 = w[1];
                        r.word2 = w[2];
                        r.word3 = w[3];
                        r.word4 = w[4];
                        r.word5 = w[5];
                        frames_due.push_back(r);
                    end
                end
            end
        endcase
    endtask

    // offer one byte, with an optional gap first, and wait until it is taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        bit taken;
        gap = 0;
        if (!steady_in && $urandom_range(99) < 17)
            gap = $urandom_range(1, 2);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        parse_rx_byte(b);
        rx_sent++;
    endtask

    // build a full frame and send it; the byte at the check position is set
    // to the right sum or to a wrong one when it falls inside the body
    task automatic send_frame(input logic [7:0] kind, input int len, input bit sum_good,
                              input int fill);
        logic [7:0] fb [260];
        logic [8:0] p;
        logic [7:0] s;
        int last;
        last  = len + 4;
        fb[0] = imu_fp_pkg::SYNC_BYTE;
        fb[1] = imu_fp_pkg::SYNC_BYTE;
        fb[2] = kind;
        fb[3] = len[7:0];
        for (int i = 4; i <= last; i++)
        begin
            case (fill)
                FILL_ZERO:    fb[i] = 8'h00;
                FILL_ONES:    fb[i] = 8'hFF;
                FILL_EXTREME: fb[i] = ((i - 4) % 4 == 0) ? 8'h00 :
                                      ((i - 4) % 4 == 1) ? 8'h80 :
                                      ((i - 4) % 4 == 2) ? 8'hFF : 8'h7F;
                default:      fb[i] = 8'($urandom_range(0, 255));
            endcase
        end
        p = kind_pos(kind);
        if (p >= 9'd4 && int'(p) <= last)
        begin
            s = 8'd0;
            for (int i = 0; i < int'(p); i++)
                s = s + fb[i];
            fb[p] = sum_good ? s : s + 8'd1;
        end
        for (int i = 0; i <= last; i++)
            send_byte(fb[i]);
    endtask

    // stop offering and wait until every pending frame result is out
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (frames_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write, mirrored into the predicted settings
    task automatic write_check_pos(input logic [1:0] index, input logic [8:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            imu_fp_pkg::CFG_ANGLE_POS:  pos_angle  = value;
            imu_fp_pkg::CFG_QUAT_POS:   pos_quat   = value;
            imu_fp_pkg::CFG_MOTION_POS: pos_motion = value;
            default:                    ;
        endcase
    endtask

    function automatic int natural_len(input logic [7:0] kind);
        case (kind)
            imu_fp_pkg::KIND_ANGLE:  return 6;
            imu_fp_pkg::KIND_QUAT:   return 8;
            imu_fp_pkg::KIND_MOTION: return 12;
            default:                 return $urandom_range(0, 16);
        endcase
    endfunction

    // reset positions, full frames with good and bad sums and extreme words
    task automatic test_default_positions();
        send_frame(imu_fp_pkg::KIND_ANGLE, 6, 1'b1, FILL_EXTREME);
        send_frame(imu_fp_pkg::KIND_QUAT, 8, 1'b0, FILL_ONES);
        send_frame(imu_fp_pkg::KIND_MOTION, 12, 1'b1, FILL_ZERO);
        send_frame(imu_fp_pkg::KIND_MOTION, 12, 1'b1, FILL_EXTREME);
    endtask

    // noise while hunting, a bad second sync byte, then a clean frame
    task automatic test_sync_recovery();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(imu_fp_pkg::SYNC_BYTE);
        send_byte(8'hAA);
        send_frame(imu_fp_pkg::KIND_ANGLE, 6, 1'b1, FILL_RANDOM);
    endtask

    // frames of unknown type are swallowed whole
    task automatic test_unknown_kinds();
        send_frame(8'h00, 4, 1'b1, FILL_RANDOM);
        send_frame(8'hFF, 0, 1'b1, FILL_ONES);
        send_frame(imu_fp_pkg::KIND_QUAT, 8, 1'b1, FILL_RANDOM);
    endtask

    // empty and short bodies leave zero words, long bodies are cut at the store
    task automatic test_short_and_long_payloads();
        send_frame(imu_fp_pkg::KIND_MOTION, 0, 1'b1, FILL_RANDOM);
        send_frame(imu_fp_pkg::KIND_QUAT, 3, 1'b1, FILL_RANDOM);
        send_frame(imu_fp_pkg::KIND_ANGLE, 20, 1'b1, FILL_RANDOM);
        send_frame(imu_fp_pkg::KIND_MOTION, 30, 1'b1, FILL_RANDOM);
    endtask

    // extreme check positions: lowest body byte, last byte, past the end, in the header
    task automatic test_check_positions();
        wait_for_results();
        write_check_pos(imu_fp_pkg::CFG_ANGLE_POS, 9'd4);
        write_check_pos(imu_fp_pkg::CFG_QUAT_POS, 9'd259);
        write_check_pos(imu_fp_pkg::CFG_MOTION_POS, 9'h1FF);
        send_frame(imu_fp_pkg::KIND_ANGLE, 6, 1'b1, FILL_RANDOM);
        send_frame(imu_fp_pkg::KIND_QUAT, 255, 1'b1, FILL_RANDOM);
        send_frame(imu_fp_pkg::KIND_MOTION, 12, 1'b1, FILL_RANDOM);
        wait_for_results();
        write_check_pos(imu_fp_pkg::CFG_ANGLE_POS, 9'd0);
        write_check_pos(imu_fp_pkg::CFG_QUAT_POS, 9'd3);
        write_check_pos(imu_fp_pkg::CFG_MOTION_POS, 9'd2);
        send_frame(imu_fp_pkg::KIND_ANGLE, 6, 1'b1, FILL_RANDOM);
        // length byte equal to the header sum makes the sum match
        send_frame(imu_fp_pkg::KIND_QUAT, 8'hAC, 1'b1, FILL_RANDOM);
        send_frame(imu_fp_pkg::KIND_MOTION, 12, 1'b1, FILL_RANDOM);
        wait_for_results();
        write_check_pos(CFG_SPARE, 9'h1FF);
        write_check_pos(imu_fp_pkg::CFG_ANGLE_POS, imu_fp_pkg::ANGLE_POS_RST);
        write_check_pos(imu_fp_pkg::CFG_QUAT_POS, imu_fp_pkg::QUAT_POS_RST);
        write_check_pos(imu_fp_pkg::CFG_MOTION_POS, imu_fp_pkg::MOTION_POS_RST);
        send_frame(imu_fp_pkg::KIND_ANGLE, 6, 1'b1, FILL_RANDOM);
    endtask

    // long receiver hold while requests keep coming, then a full pause
    task automatic test_backpressure();
        steady_in    = 1'b1;
        steady_out   = 1'b1;
        hold_request = 1'b1;
        for (int n = 0; n < 8; n++)
            send_frame(imu_fp_pkg::KIND_ANGLE, 6, 1'b1, FILL_RANDOM);
        wait_for_results();
        for (int n = 0; n < 4; n++)
            send_frame(imu_fp_pkg::KIND_QUAT, 8, 1'b1, FILL_RANDOM);
        wait_for_results();
        steady_in  = 1'b0;
        steady_out = 1'b0;
    endtask

    // mostly well formed frames with random content, some noise and broken syncs
    task automatic test_random_traffic();
        int next_cfg;
        int r;
        logic [7:0] kind;
        int len;
        next_cfg = rx_sent + CFG_INTERVAL;
        while (rx_sent < ITEM_BUDGET)
        begin
            if (rx_sent >= next_cfg)
            begin
                wait_for_results();
                write_check_pos(imu_fp_pkg::CFG_ANGLE_POS, ($urandom_range(9) < 7) ?
                                imu_fp_pkg::ANGLE_POS_RST : 9'($urandom_range(0, 511)));
                write_check_pos(imu_fp_pkg::CFG_QUAT_POS, ($urandom_range(9) < 7) ?
                                imu_fp_pkg::QUAT_POS_RST : 9'($urandom_range(0, 511)));
                write_check_pos(imu_fp_pkg::CFG_MOTION_POS, ($urandom_range(9) < 7) ?
                                imu_fp_pkg::MOTION_POS_RST : 9'($urandom_range(0, 511)));
                steady_in  = ($urandom_range(3) == 0);
                steady_out = ($urandom_range(3) == 0);
                next_cfg   = rx_sent + CFG_INTERVAL;
            end
            r = $urandom_range(99);
            if (r < 78)
            begin
                case ($urandom_range(9))
                    0, 1, 2: kind = imu_fp_pkg::KIND_ANGLE;
                    3, 4, 5: kind = imu_fp_pkg::KIND_QUAT;
                    6, 7, 8: kind = imu_fp_pkg::KIND_MOTION;
                    default: kind = 8'($urandom_range(0, 255));
                endcase
                case ($urandom_range(99)) inside
                    [0:79]:  len = natural_len(kind);
                    [80:96]: len = $urandom_range(0, 20);
                    default: len = $urandom_range(200, 255);
                endcase
                send_frame(kind, len, $urandom_range(9) != 0, FILL_RANDOM);
            end
            else if (r < 90)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom_range(0, 255)));
            end
            else
            begin
                send_byte(imu_fp_pkg::SYNC_BYTE);
                send_byte(8'($urandom_range(0, 84)));
            end
        end
        steady_in  = 1'b0;
        steady_out = 1'b0;
    endtask

    // receiver: random stalls, quiet stretches and one long hold
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else
                out_stall <= !steady_out && ($urandom_range(99) < 21);
        end
    end

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $error("%s expected %0d got %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    // compare each taken result with the oldest predicted frame
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (frames_due.size() == 0)
            begin
                $error("frame result with none pending");
                errors++;
            end
            else
            begin
                want = frames_due.pop_front();
                check_field("category", want.category, category);
                check_field("checksum_ok", want.checksum_ok, checksum_ok);
                check_field("word0", want.word0, word0);
                check_field("word1", want.word1, word1);
                check_field("word2", want.word2, word2);
                check_field("word3", want.word3, word3);
                check_field("word4", want.word4, word4);
                check_field("word5", want.word5, word5);
            end
        end
    end

    // watchdog on cycles without any handshake
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("imu_frame_parser_top: mismatch");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = 8'd0;
        out_stall    = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = imu_fp_pkg::CFG_ANGLE_POS;
        cfg_data     = 9'd0;
        errors       = 0;
        rx_sent      = 0;
        steady_in    = 1'b0;
        steady_out   = 1'b0;
        hold_request = 1'b0;
        ph           = HUNT_FIRST;
        idx          = 9'd0;
        kind_r       = 8'd0;
        len_r        = 8'd0;
        sum_r        = 8'd0;
        chk_r        = 8'd0;
        seen_r       = 1'b0;
        for (int i = 0; i < imu_fp_pkg::PAYLOAD_KEEP; i++)
            store[i] = 8'd0;
        pos_angle  = imu_fp_pkg::ANGLE_POS_RST;
        pos_quat   = imu_fp_pkg::QUAT_POS_RST;
        pos_motion = imu_fp_pkg::MOTION_POS_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_positions();
        test_sync_recovery();
        test_unknown_kinds();
        test_short_and_long_payloads();
        test_check_positions();
        test_backpressure();
        test_random_traffic();

        wait_for_results();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("imu_frame_parser_top: match");
        else
            $display("imu_frame_parser_top: mismatch");
        $finish;
    end

endmodule
